/* hdl/xcf_rle_pkg.sv */
`timescale 1ns / 1ps
// xcf_rle_pkg: shared types and constants for the tile run-length decoder
// used by xcf_rle_core, xcf_rle_skid and xcf_tile_rle_decoder; no dependencies

package xcf_rle_pkg;

   localparam int TILE_SIDE    = 64;
   localparam int MAX_CHANNELS = 4;

   localparam int BYTE_W   = 8;
   localparam int BPP_W    = 3;
   localparam int DIM_W    = 7;
   localparam int CHAN_W   = 2;
   localparam int PIXEL_W  = 12;
   localparam int SAMPLE_W = 13;
   localparam int RUN_W    = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 7;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BYTES_PER_PIXEL = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TILE_WIDTH      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TILE_HEIGHT     = 2'd2;

   // decoded header length that is replaced by a 16-bit count
   localparam logic [BYTE_W-1:0] LONG_RUN_LEN = 8'd128;

   typedef enum logic [4:0] {
      PH_HEADER   = 5'b00001,
      PH_COUNT_HI = 5'b00010,
      PH_COUNT_LO = 5'b00100,
      PH_LITERAL  = 5'b01000,
      PH_VALUE    = 5'b10000
   } phase_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              tile_start;
   } req_item_type;

   typedef struct packed {
      logic [CHAN_W-1:0]   channel;
      logic [PIXEL_W-1:0]  pixel_index;
      logic [BYTE_W-1:0]   sample_value;
      logic [SAMPLE_W-1:0] run_length;
      logic                overrun;
      logic                tile_done;
   } rsp_item_type;

   // clamps a tile dimension into 1..TILE_SIDE
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (v > DIM_W'(TILE_SIDE)) begin
         r = DIM_W'(TILE_SIDE);
      end
      return r;
   endfunction

   // clamps the channel count into 1..MAX_CHANNELS
   function automatic logic [BPP_W-1:0] clamp_channels(input logic [BPP_W-1:0] v);
      logic [BPP_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = BPP_W'(1);
      end else if (v > BPP_W'(MAX_CHANNELS)) begin
         r = BPP_W'(MAX_CHANNELS);
      end
      return r;
   endfunction

endpackage

/* hdl/xcf_rle_core.sv */
`timescale 1ns / 1ps
// xcf_rle_core: configuration registers and the per-byte decode state machine
// depends on xcf_rle_pkg

module xcf_rle_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_en,
   input  logic [xcf_rle_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [xcf_rle_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                                accept,
   input  xcf_rle_pkg::req_item_type           req_item,
   output logic                                push,
   output xcf_rle_pkg::rsp_item_type           push_item
);

   logic [xcf_rle_pkg::BPP_W-1:0] bpp_ff;
   logic [xcf_rle_pkg::DIM_W-1:0] width_ff;
   logic [xcf_rle_pkg::DIM_W-1:0] height_ff;

   xcf_rle_pkg::phase_type             phase_ff, phase_in;
   logic [xcf_rle_pkg::RUN_W-1:0]      run_ff, run_in;
   logic                               lit_ff, lit_in;
   logic [xcf_rle_pkg::CHAN_W-1:0]     chan_ff, chan_in;
   logic [xcf_rle_pkg::SAMPLE_W-1:0]   samples_ff, samples_in;
   logic [xcf_rle_pkg::PIXEL_W-1:0]    pixel_ff, pixel_in;
   logic                               active_ff, active_in;
   logic                               over_ff, over_in;

   xcf_rle_pkg::phase_type             cur_phase;
   logic [xcf_rle_pkg::RUN_W-1:0]      cur_run;
   logic                               cur_lit;
   logic [xcf_rle_pkg::CHAN_W-1:0]     cur_chan;
   logic [xcf_rle_pkg::SAMPLE_W-1:0]   cur_samples;
   logic [xcf_rle_pkg::PIXEL_W-1:0]    cur_pixel;
   logic                               cur_active;
   logic                               cur_over;

   logic [xcf_rle_pkg::BYTE_W-1:0]     b;
   logic                               ts;
   logic [xcf_rle_pkg::SAMPLE_W-1:0]   plane;
   logic [xcf_rle_pkg::BPP_W-1:0]      eff_ch;
   logic                               last_ch;
   logic [8:0]                         hdr_len9;
   logic [xcf_rle_pkg::BYTE_W-1:0]     hdr_len;
   logic [xcf_rle_pkg::RUN_W-1:0]      br_len;
   logic                               br_lit;
   logic                               br_over;
   xcf_rle_pkg::phase_type             br_phase;
   logic [xcf_rle_pkg::SAMPLE_W-1:0]   run_min;
   logic [xcf_rle_pkg::SAMPLE_W-1:0]   emit_len;
   logic                               emit_ok;
   logic [xcf_rle_pkg::SAMPLE_W-1:0]   rest;
   logic [xcf_rle_pkg::SAMPLE_W-1:0]   samples_after;
   logic                               chan_end;
   logic [xcf_rle_pkg::RUN_W-1:0]      run_dec;

   assign b  = req_item.data_byte;
   assign ts = req_item.tile_start;

   assign plane = xcf_rle_pkg::SAMPLE_W'(
      {6'd0, xcf_rle_pkg::clamp_dim(width_ff)} * {6'd0, xcf_rle_pkg::clamp_dim(height_ff)});
   assign eff_ch = xcf_rle_pkg::clamp_channels(bpp_ff);

   // state as seen after an optional restart
   assign cur_phase   = ts ? xcf_rle_pkg::PH_HEADER : phase_ff;
   assign cur_run     = ts ? '0 : run_ff;
   assign cur_lit     = ts ? 1'b0 : lit_ff;
   assign cur_chan    = ts ? '0 : chan_ff;
   assign cur_samples = ts ? plane : samples_ff;
   assign cur_pixel   = ts ? '0 : pixel_ff;
   assign cur_active  = ts | active_ff;
   assign cur_over    = ts ? 1'b0 : over_ff;

   assign last_ch = ({1'b0, cur_chan} + 3'd1) >= eff_ch;

   // header length and run start
   assign hdr_len9 = b[7] ? (9'd256 - {1'b0, b}) : ({1'b0, b} + 9'd1);
   assign hdr_len  = hdr_len9[7:0];
   assign br_len   = (cur_phase == xcf_rle_pkg::PH_HEADER) ? {8'd0, hdr_len}
                                                           : {cur_run[15:8], b};
   assign br_lit   = (cur_phase == xcf_rle_pkg::PH_HEADER) ? b[7] : cur_lit;
   assign br_over  = br_len > {3'd0, cur_samples};
   assign br_phase = br_lit ? ((br_len != '0) ? xcf_rle_pkg::PH_LITERAL
                                              : xcf_rle_pkg::PH_HEADER)
                            : xcf_rle_pkg::PH_VALUE;

   // emission
   assign run_min  = ((cur_run[15:13] != '0) || (cur_run[12:0] > cur_samples))
                     ? cur_samples : cur_run[12:0];
   assign emit_len = (cur_phase == xcf_rle_pkg::PH_LITERAL) ? 13'd1 : run_min;
   assign emit_ok  = (cur_phase == xcf_rle_pkg::PH_LITERAL) ? (cur_samples != '0)
                                                            : (run_min != '0);
   assign rest          = cur_samples - emit_len;
   assign samples_after = emit_ok ? rest : cur_samples;
   assign run_dec       = cur_run - 16'd1;

   always_comb begin
      phase_in   = cur_phase;
      run_in     = cur_run;
      lit_in     = cur_lit;
      chan_in    = cur_chan;
      samples_in = cur_samples;
      pixel_in   = cur_pixel;
      active_in  = cur_active;
      over_in    = cur_over;
      push       = 1'b0;
      chan_end   = 1'b0;

      push_item.channel      = cur_chan;
      push_item.pixel_index  = cur_pixel;
      push_item.sample_value = b;
      push_item.run_length   = emit_len;
      push_item.overrun      = cur_over;
      push_item.tile_done    = (rest == '0) && last_ch;

      if (cur_active) begin
         case (cur_phase)
            xcf_rle_pkg::PH_HEADER: begin
               lit_in = b[7];
               if (hdr_len == xcf_rle_pkg::LONG_RUN_LEN) begin
                  phase_in = xcf_rle_pkg::PH_COUNT_HI;
               end else begin
                  over_in  = br_over;
                  run_in   = br_len;
                  phase_in = br_phase;
               end
            end
            xcf_rle_pkg::PH_COUNT_HI: begin
               run_in   = {b, 8'd0};
               phase_in = xcf_rle_pkg::PH_COUNT_LO;
            end
            xcf_rle_pkg::PH_COUNT_LO: begin
               over_in  = br_over;
               run_in   = br_len;
               phase_in = br_phase;
            end
            xcf_rle_pkg::PH_LITERAL: begin
               run_in = run_dec;
               if (emit_ok) begin
                  push       = 1'b1;
                  samples_in = rest;
                  pixel_in   = cur_pixel + emit_len[xcf_rle_pkg::PIXEL_W-1:0];
               end
               if (run_dec == '0) begin
                  phase_in = xcf_rle_pkg::PH_HEADER;
                  chan_end = (samples_after == '0);
               end
            end
            xcf_rle_pkg::PH_VALUE: begin
               run_in   = '0;
               phase_in = xcf_rle_pkg::PH_HEADER;
               if (emit_ok) begin
                  push       = 1'b1;
                  samples_in = rest;
                  pixel_in   = cur_pixel + emit_len[xcf_rle_pkg::PIXEL_W-1:0];
               end
               chan_end = (samples_after == '0);
            end
            default: begin
               phase_in = xcf_rle_pkg::PH_HEADER;
            end
         endcase

         if (chan_end) begin
            if (last_ch) begin
               active_in = 1'b0;
            end else begin
               chan_in    = cur_chan + 2'd1;
               pixel_in   = '0;
               samples_in = plane;
            end
            phase_in = xcf_rle_pkg::PH_HEADER;
            run_in   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bpp_ff    <= xcf_rle_pkg::BPP_W'(xcf_rle_pkg::MAX_CHANNELS);
         width_ff  <= xcf_rle_pkg::DIM_W'(xcf_rle_pkg::TILE_SIDE);
         height_ff <= xcf_rle_pkg::DIM_W'(xcf_rle_pkg::TILE_SIDE);
      end else if (csr_write_en) begin
         case (csr_index)
            xcf_rle_pkg::CSR_BYTES_PER_PIXEL: begin
               bpp_ff <= csr_wdata[xcf_rle_pkg::BPP_W-1:0];
            end
            xcf_rle_pkg::CSR_TILE_WIDTH: begin
               width_ff <= csr_wdata;
            end
            xcf_rle_pkg::CSR_TILE_HEIGHT: begin
               height_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= xcf_rle_pkg::PH_HEADER;
         run_ff     <= '0;
         lit_ff     <= 1'b0;
         chan_ff    <= '0;
         samples_ff <= '0;
         pixel_ff   <= '0;
         active_ff  <= 1'b0;
         over_ff    <= 1'b0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         run_ff     <= run_in;
         lit_ff     <= lit_in;
         chan_ff    <= chan_in;
         samples_ff <= samples_in;
         pixel_ff   <= pixel_in;
         active_ff  <= active_in;
         over_ff    <= over_in;
      end
   end

   // no result without an active or starting tile
   a_idle_no_result: assert property (@(posedge clock) disable iff (reset)
      (!active_ff && !ts) |-> !push)
      else $error("result produced while no tile is active");

   // a literal run in progress always has bytes left
   a_literal_run_left: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == xcf_rle_pkg::PH_LITERAL) |-> (run_ff != '0))
      else $error("literal phase with empty run");

   // a result never claims more samples than remain in the channel
   a_emit_within_plane: assert property (@(posedge clock) disable iff (reset)
      push |-> (push_item.run_length != '0) && (push_item.run_length <= cur_samples))
      else $error("result run exceeds samples left");

endmodule

/* hdl/xcf_rle_skid.sv */
`timescale 1ns / 1ps
// xcf_rle_skid: two-entry result register with skid stage
// depends on xcf_rle_pkg

module xcf_rle_skid (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  xcf_rle_pkg::rsp_item_type  push_item,
   output logic                       full,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output xcf_rle_pkg::rsp_item_type  rsp_data
);

   logic                       main_valid_ff, main_valid_in;
   logic                       skid_valid_ff, skid_valid_in;
   xcf_rle_pkg::rsp_item_type  main_ff, main_in;
   xcf_rle_pkg::rsp_item_type  skid_ff, skid_in;
   logic                       take;

   assign take      = main_valid_ff && !rsp_stall;
   assign full      = skid_valid_ff;
   assign rsp_valid = main_valid_ff;
   assign rsp_data  = main_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (take) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!main_valid_ff || take) begin
            main_in       = push_item;
            main_valid_in = 1'b1;
         end else begin
            skid_in       = push_item;
            skid_valid_in = 1'b1;
         end
      end else if (take) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   // skid entry only holds an item behind a waiting one
   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid entry valid with empty output register");

   // a taken item is replaced by the skid entry in order
   a_skid_moves_up: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && take) |=> (main_valid_ff && !skid_valid_ff
                                   && main_ff == $past(skid_ff)))
      else $error("skid entry not moved to output register");

   // an item pushed into an empty register shows up next cycle
   a_push_lands: assert property (@(posedge clock) disable iff (reset)
      (push && !main_valid_ff) |=> (main_valid_ff && main_ff == $past(push_item)))
      else $error("pushed item lost");

endmodule

/* hdl/xcf_tile_rle_decoder.sv */
`timescale 1ns / 1ps
// xcf_tile_rle_decoder: top level of the compressed tile run-length decoder
// depends on xcf_rle_pkg, xcf_rle_core and xcf_rle_skid
//
//   port group   direction   handshake            payload
//   req_         in          req_valid/req_stall  req_data  (data_byte, tile_start)
//   rsp_         out         rsp_valid/rsp_stall  rsp_data  (channel .. tile_done)
//   csr_         in          csr_write_en         csr_index, csr_wdata
//
// one byte is taken per cycle while req_stall is low; its result is on rsp_data the next
// cycle unless an earlier item still waits there
// the decode state advances once per accepted byte, with no loops between bytes
// a two-entry output register lets one more result land in the skid entry under rsp_stall
// req_stall rises only once both output entries are full
// synchronous reset: tile idle, registers 4 channels, 64 by 64

module xcf_tile_rle_decoder (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  xcf_rle_pkg::req_item_type           req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output xcf_rle_pkg::rsp_item_type           rsp_data,
   input  logic                                csr_write_en,
   input  logic [xcf_rle_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [xcf_rle_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   logic                       accept;
   logic                       push;
   logic                       full;
   xcf_rle_pkg::rsp_item_type  push_item;

   assign req_stall = full;
   assign accept    = req_valid && !full;

   xcf_rle_core u_core (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .accept       (accept),
      .req_item     (req_data),
      .push         (push),
      .push_item    (push_item)
   );

   xcf_rle_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .push      (push && accept),
      .push_item (push_item),
      .full      (full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

/* test/xcf_tile_rle_decoder_test.sv */
`timescale 1ns / 1ps
// xcf_tile_rle_decoder_test: self-checking testbench for the tile run-length decoder
// directed stream table, then random tiles checked against a local decode model
// depends on xcf_rle_pkg and xcf_tile_rle_decoder

module xcf_tile_rle_decoder_test;

   localparam int CYCLE_LIMIT = 200000;
   localparam int SETTLE_CYCLES = 8;

   typedef struct packed {
      logic                      set_regs;
      logic [2:0]                bpp;
      logic [6:0]                wid;
      logic [6:0]                hgt;
      logic [7:0]                data_byte;
      logic                      tile_start;
      logic                      typed;
      logic                      yields;
      xcf_rle_pkg::rsp_item_type rsp;
   } script_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   xcf_rle_pkg::req_item_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   xcf_rle_pkg::rsp_item_type rsp_data;
   logic csr_write_en = 1'b0;
   logic [xcf_rle_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [xcf_rle_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   // decode model state
   logic [2:0] cfg_bpp = 3'd4;
   logic [6:0] cfg_w = 7'd64;
   logic [6:0] cfg_h = 7'd64;
   xcf_rle_pkg::phase_type dec_phase = xcf_rle_pkg::PH_HEADER;
   int run_cnt = 0;
   bit lit_mode = 1'b0;
   int chan = 0;
   int left = 0;
   int pos = 0;
   bit active = 1'b0;
   bit over = 1'b0;

   xcf_rle_pkg::rsp_item_type pending_rsp[$];
   int fail_count = 0;
   int cycle_count = 0;
   int idle_pct = 0;
   int stall_pct = 0;

   always #5 clock = ~clock;

   xcf_tile_rle_decoder dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   function automatic int chan_count(logic [2:0] v);
      if (v == 3'd0) return 1;
      if (v > 3'd4) return 4;
      return int'(v);
   endfunction

   function automatic int side(logic [6:0] v);
      if (v == 7'd0) return 1;
      if (int'(v) > xcf_rle_pkg::TILE_SIDE) return xcf_rle_pkg::TILE_SIDE;
      return int'(v);
   endfunction

   function automatic void start_run(int len);
      over = (len > left);
      run_cnt = len % 65536;
      if (lit_mode) begin
         dec_phase = (run_cnt != 0) ? xcf_rle_pkg::PH_LITERAL : xcf_rle_pkg::PH_HEADER;
      end else begin
         dec_phase = xcf_rle_pkg::PH_VALUE;
      end
   endfunction

   function automatic void end_channel();
      if (chan + 1 >= chan_count(cfg_bpp)) begin
         active = 1'b0;
      end else begin
         chan = (chan + 1) % 4;
         pos = 0;
         left = side(cfg_w) * side(cfg_h);
      end
      dec_phase = xcf_rle_pkg::PH_HEADER;
      run_cnt = 0;
   endfunction

   function automatic void emit_run(logic [7:0] b, int len,
                                    output xcf_rle_pkg::rsp_item_type r);
      int rest;
      rest = left - len;
      r.channel = chan[1:0];
      r.pixel_index = pos[11:0];
      r.sample_value = b;
      r.run_length = len[12:0];
      r.overrun = over;
      r.tile_done = (rest == 0 && chan + 1 >= chan_count(cfg_bpp));
      left = rest;
      pos = (pos + len) % 4096;
   endfunction

   function automatic void decode_byte(input logic [7:0] b, input logic st,
                                       output bit yields,
                                       output xcf_rle_pkg::rsp_item_type r);
      int len;
      yields = 1'b0;
      r = '0;
      if (st) begin
         chan = 0;
         pos = 0;
         left = side(cfg_w) * side(cfg_h);
         active = 1'b1;
         dec_phase = xcf_rle_pkg::PH_HEADER;
         run_cnt = 0;
         over = 1'b0;
         lit_mode = 1'b0;
      end
      if (!active) return;
      case (dec_phase)
         xcf_rle_pkg::PH_HEADER: begin
            lit_mode = b[7];
            len = b[7] ? 256 - int'(b) : int'(b) + 1;
            if (len == int'(xcf_rle_pkg::LONG_RUN_LEN)) begin
               dec_phase = xcf_rle_pkg::PH_COUNT_HI;
            end else begin
               start_run(len);
            end
         end
         xcf_rle_pkg::PH_COUNT_HI: begin
            run_cnt = int'(b) << 8;
            dec_phase = xcf_rle_pkg::PH_COUNT_LO;
         end
         xcf_rle_pkg::PH_COUNT_LO: begin
            start_run(run_cnt | int'(b));
         end
         xcf_rle_pkg::PH_LITERAL: begin
            run_cnt = run_cnt - 1;
            if (left > 0) begin
               emit_run(b, 1, r);
               yields = 1'b1;
            end
            if (run_cnt == 0) begin
               dec_phase = xcf_rle_pkg::PH_HEADER;
               if (left == 0) end_channel();
            end
         end
         xcf_rle_pkg::PH_VALUE: begin
            len = (run_cnt > left) ? left : run_cnt;
            run_cnt = 0;
            dec_phase = xcf_rle_pkg::PH_HEADER;
            if (len > 0) begin
               emit_run(b, len, r);
               yields = 1'b1;
            end
            if (left == 0) end_channel();
         end
         default: begin
            dec_phase = xcf_rle_pkg::PH_HEADER;
         end
      endcase
   endfunction

   function automatic logic [6:0] pick_dim();
      case ($urandom_range(19))
         0: return 7'd0;
         1: return 7'd64;
         2: return 7'($urandom_range(65, 127));
         3: return 7'd1;
         default: return 7'($urandom_range(1, 8));
      endcase
   endfunction

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_regs(logic [2:0] bpp, logic [6:0] w, logic [6:0] h);
      wait_idle();
      csr_write_en <= 1'b1;
      csr_index <= xcf_rle_pkg::CSR_BYTES_PER_PIXEL;
      csr_wdata <= {4'($urandom), bpp};
      @(posedge clock);
      cfg_bpp = bpp;
      csr_index <= xcf_rle_pkg::CSR_TILE_WIDTH;
      csr_wdata <= w;
      @(posedge clock);
      cfg_w = w;
      csr_index <= xcf_rle_pkg::CSR_TILE_HEIGHT;
      csr_wdata <= h;
      @(posedge clock);
      cfg_h = h;
      csr_write_en <= 1'b0;
   endtask

   task automatic send_byte(input logic [7:0] b, input logic st,
                            output bit yields, output xcf_rle_pkg::rsp_item_type r);
      int gap;
      gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 4) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{data_byte: b, tile_start: st};
      do @(posedge clock); while (req_stall);
      decode_byte(b, st, yields, r);
   endtask

   // well-formed tile for the current sizes, sometimes cut short or followed by noise
   task automatic build_tile(ref xcf_rle_pkg::req_item_type tile[$]);
      int left_n;
      int len;
      bit literal;
      bit long_form;
      for (int c = 0; c < chan_count(cfg_bpp); c++) begin
         left_n = side(cfg_w) * side(cfg_h);
         while (left_n > 0) begin
            literal = ($urandom_range(99) < ((left_n > 64) ? 20 : 50));
            if ($urandom_range(24) == 0) begin
               len = 0;
            end else if ($urandom_range(19) == 0) begin
               if (left_n > 8) literal = 1'b0;
               if (literal) len = left_n + $urandom_range(1, 3);
               else if ($urandom_range(3) == 0) len = $urandom_range(left_n + 1, 65535);
               else len = left_n + $urandom_range(1, 300);
            end else if (literal) begin
               len = $urandom_range(1, (left_n < 6) ? left_n : 6);
            end else if ($urandom_range(3) == 0 || left_n > 64) begin
               len = $urandom_range(1, left_n);
            end else begin
               len = $urandom_range(1, (left_n < 8) ? left_n : 8);
            end
            long_form = (len == 0 || len >= 128 || $urandom_range(9) == 0);
            if (long_form) begin
               tile.push_back('{literal ? 8'h80 : 8'h7F, 1'b0});
               tile.push_back('{8'(len >> 8), 1'b0});
               tile.push_back('{8'(len), 1'b0});
            end else begin
               tile.push_back('{literal ? 8'(256 - len) : 8'(len - 1), 1'b0});
            end
            repeat (literal ? len : 1) tile.push_back('{8'($urandom), 1'b0});
            left_n -= (len > left_n) ? left_n : len;
         end
      end
      tile[0].tile_start = 1'b1;
      if ($urandom_range(9) == 0) tile = tile[0:$urandom_range(0, tile.size() - 1)];
      if ($urandom_range(9) == 0) begin
         repeat ($urandom_range(1, 6)) tile.push_back('{8'($urandom), $urandom_range(15) == 0});
      end
   endtask

   always @(posedge clock) begin
      xcf_rle_pkg::rsp_item_type want;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL xcf_tile_rle_decoder");
         $finish;
      end else begin
         if (!reset && rsp_valid && !rsp_stall) begin
            if (pending_rsp.size() == 0) begin
               $error("unexpected item: channel %0d pixel %0d value %0h run %0d",
                      rsp_data.channel, rsp_data.pixel_index, rsp_data.sample_value,
                      rsp_data.run_length);
               fail_count++;
            end else begin
               want = pending_rsp.pop_front();
               if (rsp_data.channel !== want.channel) begin
                  $error("channel: expected %0d, got %0d", want.channel, rsp_data.channel);
                  fail_count++;
               end
               if (rsp_data.pixel_index !== want.pixel_index) begin
                  $error("pixel_index: expected %0d, got %0d",
                         want.pixel_index, rsp_data.pixel_index);
                  fail_count++;
               end
               if (rsp_data.sample_value !== want.sample_value) begin
                  $error("sample_value: expected %0h, got %0h",
                         want.sample_value, rsp_data.sample_value);
                  fail_count++;
               end
               if (rsp_data.run_length !== want.run_length) begin
                  $error("run_length: expected %0d, got %0d",
                         want.run_length, rsp_data.run_length);
                  fail_count++;
               end
               if (rsp_data.overrun !== want.overrun) begin
                  $error("overrun: expected %0d, got %0d", want.overrun, rsp_data.overrun);
                  fail_count++;
               end
               if (rsp_data.tile_done !== want.tile_done) begin
                  $error("tile_done: expected %0d, got %0d",
                         want.tile_done, rsp_data.tile_done);
                  fail_count++;
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   initial begin
      script_row_type script[$];
      xcf_rle_pkg::req_item_type tile[$];
      bit yields;
      xcf_rle_pkg::rsp_item_type got;
      int item_count;
      int target;
      int idle_set[4];
      int stall_set[4];
      logic [2:0] bpp_set[4];
      logic [6:0] w_set[4];
      logic [6:0] h_set[4];

      // set_regs, bpp, wid, hgt, byte, start, typed, yields, result
      script = '{
         '{0, 0, 0, 0, 8'h33, 0, 1, 0, '0},                            // idle byte
         '{0, 0, 0, 0, 8'h7F, 1, 1, 0, '0},                            // long repeat
         '{0, 0, 0, 0, 8'h10, 0, 1, 0, '0},
         '{0, 0, 0, 0, 8'h00, 0, 1, 0, '0},
         '{0, 0, 0, 0, 8'hAB, 0, 1, 1, '{0, 0, 8'hAB, 4096, 0, 0}},
         '{0, 0, 0, 0, 8'h7F, 0, 1, 0, '0},                            // overshooting repeat
         '{0, 0, 0, 0, 8'hFF, 0, 1, 0, '0},
         '{0, 0, 0, 0, 8'hFF, 0, 1, 0, '0},
         '{0, 0, 0, 0, 8'h00, 0, 1, 1, '{1, 0, 8'h00, 4096, 1, 0}},
         '{0, 0, 0, 0, 8'h80, 0, 0, 0, '0},                            // empty literal
         '{0, 0, 0, 0, 8'h00, 0, 0, 0, '0},
         '{0, 0, 0, 0, 8'h00, 0, 0, 0, '0},
         '{0, 0, 0, 0, 8'h00, 0, 0, 0, '0},
         '{0, 0, 0, 0, 8'hFF, 0, 1, 1, '{2, 0, 8'hFF, 1, 0, 0}},
         '{0, 0, 0, 0, 8'hFF, 0, 0, 0, '0},
         '{0, 0, 0, 0, 8'h55, 0, 1, 1, '{2, 1, 8'h55, 1, 0, 0}},
         '{0, 0, 0, 0, 8'h7F, 1, 0, 0, '0},                            // restart mid tile
         '{0, 0, 0, 0, 8'h00, 0, 0, 0, '0},                            // empty repeat
         '{0, 0, 0, 0, 8'h00, 0, 0, 0, '0},
         '{0, 0, 0, 0, 8'h77, 0, 0, 0, '0},
         '{1, 1, 1, 2, 8'h00, 0, 0, 0, '0},
         '{0, 0, 0, 0, 8'hFD, 1, 1, 0, '0},                            // overshooting literal
         '{0, 0, 0, 0, 8'h01, 0, 1, 1, '{0, 0, 8'h01, 1, 1, 0}},
         '{0, 0, 0, 0, 8'h02, 0, 1, 1, '{0, 1, 8'h02, 1, 1, 1}},
         '{0, 0, 0, 0, 8'h03, 0, 1, 0, '0},
         '{0, 0, 0, 0, 8'h44, 0, 1, 0, '0}
      };
      idle_set = '{0, 45, 0, 8};
      stall_set = '{0, 0, 45, 8};
      bpp_set = '{3'd0, 3'd7, 3'd4, 3'd2};
      w_set = '{7'd0, 7'd127, 7'd64, 7'd1};
      h_set = '{7'd0, 7'd127, 7'd1, 7'd64};
      item_count = 0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         if (script[i].set_regs) begin
            write_regs(script[i].bpp, script[i].wid, script[i].hgt);
         end else begin
            send_byte(script[i].data_byte, script[i].tile_start, yields, got);
            if (script[i].typed) begin
               if (script[i].yields) pending_rsp.push_back(script[i].rsp);
            end else if (yields) begin
               pending_rsp.push_back(got);
            end
         end
      end

      for (int p = 0; p < 4; p++) begin
         idle_pct = idle_set[p];
         stall_pct = stall_set[p];
         write_regs(bpp_set[p], w_set[p], h_set[p]);
         target = item_count + 225;
         while (item_count < target) begin
            if ($urandom_range(3) == 0) begin
               write_regs(3'($urandom_range(0, 7)), pick_dim(), pick_dim());
            end
            tile.delete();
            build_tile(tile);
            foreach (tile[k]) begin
               if (tile[k].tile_start || active) item_count++;
               send_byte(tile[k].data_byte, tile[k].tile_start, yields, got);
               if (yields) pending_rsp.push_back(got);
            end
         end
      end

      wait_idle();
      if (fail_count == 0) begin
         $display("PASS xcf_tile_rle_decoder");
      end else begin
         $display("FAIL xcf_tile_rle_decoder");
      end
      $finish;
   end

endmodule

/* filelist.f */
hdl/xcf_rle_pkg.sv
hdl/xcf_rle_core.sv
hdl/xcf_rle_skid.sv
hdl/xcf_tile_rle_decoder.sv
test/xcf_tile_rle_decoder_test.sv
